/* sv/assert_macros.svh */
// assertion macros shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define BFA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs through reset
`define BFA_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/bfa_pkg.sv */
// shared types and constants of the bitmap block allocator
package bfa_pkg;

   localparam int ADDR_W = 32;
   localparam int SIZE_W = 16;
   localparam int STEP_W = $clog2(ADDR_W);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE   = 1'b1;

   localparam logic [ADDR_W-1:0] BASE_ADDRESS_RESET = 32'd0;
   localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET   = 16'd16;

   typedef struct packed {
      logic              opcode;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] block_address;
   } rsp_type;

   typedef enum logic [2:0] {
      DP_HOLD,
      DP_LOAD_BASE,
      DP_ADD_SIZE,
      DP_SUB_BASE,
      DP_DIV_STEP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_ctrl_type;

   typedef struct packed {
      logic              no_borrow;
      logic [ADDR_W-1:0] acc;
   } dp_stat_type;

endpackage

/* sv/bfa_dp.sv */
// shared add/subtract unit with the address accumulator and divider registers
`include "assert_macros.svh"

module bfa_dp
   import bfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  dp_ctrl_type       ctrl,
   input  logic [ADDR_W-1:0] base_address,
   input  logic [SIZE_W-1:0] block_size,
   input  logic [ADDR_W-1:0] free_address,
   output dp_stat_type       stat
);

   logic [ADDR_W-1:0] acc_ff, acc_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic              carry_ff, carry_in;

   logic [ADDR_W-1:0] a_op, b_op;
   logic              sub;
   logic [ADDR_W:0]   sum;
   logic [SIZE_W:0]   shifted;

   // partial remainder with the next dividend bit shifted in
   assign shifted = {rem_ff, acc_ff[ADDR_W-1]};

   always_comb begin
      unique case (ctrl.op)
         DP_ADD_SIZE: begin
            a_op = acc_ff;
            b_op = ADDR_W'(block_size);
            sub  = 1'b0;
         end
         DP_SUB_BASE: begin
            a_op = free_address;
            b_op = base_address;
            sub  = 1'b1;
         end
         DP_DIV_STEP: begin
            a_op = ADDR_W'(shifted);
            b_op = ADDR_W'(block_size);
            sub  = 1'b1;
         end
         default: begin
            a_op = acc_ff;
            b_op = '0;
            sub  = 1'b0;
         end
      endcase
      // the one adder; on subtract the top bit means no borrow
      sum = {1'b0, a_op} + {1'b0, b_op ^ {ADDR_W{sub}}} + (ADDR_W+1)'(sub);
   end

   always_comb begin
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      carry_in = carry_ff;
      unique case (ctrl.op)
         DP_LOAD_BASE: acc_in = base_address;
         DP_ADD_SIZE:  acc_in = sum[ADDR_W-1:0];
         DP_SUB_BASE: begin
            acc_in   = sum[ADDR_W-1:0];
            rem_in   = '0;
            carry_in = sum[ADDR_W];
         end
         DP_DIV_STEP: begin
            acc_in = {acc_ff[ADDR_W-2:0], sum[ADDR_W]};
            rem_in = sum[ADDR_W] ? sum[SIZE_W-1:0] : shifted[SIZE_W-1:0];
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      carry_ff <= carry_in;
   end

   assign stat.no_borrow = carry_ff;
   assign stat.acc       = acc_ff;

   `BFA_ASSERT(a_rem_below_size, clock, reset, ctrl.op == DP_DIV_STEP |=> rem_ff < $past(block_size), "partial remainder not below block size")

endmodule

/* sv/bfa_seq.sv */
// sequencer: free map, block scan, division steps and result register
`include "assert_macros.svh"

module bfa_seq
   import bfa_pkg::*;
#(
   parameter int NUM_BLOCKS = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req,
   input  logic [SIZE_W-1:0] block_size,
   output dp_ctrl_type       dp_ctrl,
   input  dp_stat_type       dp_stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_BLOCKS - 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ADDR_W - 1);

   typedef enum logic [6:0] {
      S_INIT   = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_ALLOC  = 7'b0000100,
      S_OFFSET = 7'b0001000,
      S_DIV    = 7'b0010000,
      S_LOOKUP = 7'b0100000,
      S_CHECK  = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   // free map, a set entry marks a free block
   logic                  free_mem [NUM_BLOCKS];
   logic                  map_rd_ff;
   logic [IDX_W-1:0]      map_raddr;
   logic                  map_we;
   logic [IDX_W-1:0]      map_waddr;
   logic                  map_wdata;

   logic             slot_free;
   logic             finish;
   rsp_type          result;
   logic             quot_in_range;
   logic [IDX_W-1:0] quot_idx;

   assign slot_free     = !rsp_valid_ff || !rsp_stall;
   assign quot_in_range = dp_stat.acc < ADDR_W'(NUM_BLOCKS);
   assign quot_idx      = dp_stat.acc[IDX_W-1:0];

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      step_in    = step_ff;
      dp_ctrl.op = DP_HOLD;
      finish     = 1'b0;
      result     = '0;
      map_raddr  = idx_ff;
      map_we     = 1'b0;
      map_waddr  = idx_ff;
      map_wdata  = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            // clearing pass, one entry per cycle
            map_we    = 1'b1;
            map_wdata = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req.opcode == OP_ALLOC) begin
                  dp_ctrl.op = DP_LOAD_BASE;
                  idx_in     = '0;
                  map_raddr  = '0;
                  state_in   = S_ALLOC;
               end else begin
                  dp_ctrl.op = DP_SUB_BASE;
                  state_in   = S_OFFSET;
               end
            end
         end
         S_ALLOC: begin
            if (map_rd_ff) begin
               if (slot_free) begin
                  finish               = 1'b1;
                  result.ok            = 1'b1;
                  result.block_address = dp_stat.acc;
                  map_we               = 1'b1;
                  state_in             = S_IDLE;
               end
            end else if (idx_ff == LAST_IDX) begin
               if (slot_free) begin
                  finish   = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               idx_in     = idx_ff + 1'b1;
               map_raddr  = idx_ff + 1'b1;
               dp_ctrl.op = DP_ADD_SIZE;
            end
         end
         S_OFFSET: begin
            if (!dp_stat.no_borrow || block_size == '0) begin
               if (slot_free) begin
                  finish   = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               // first division step rides on the borrow check
               dp_ctrl.op = DP_DIV_STEP;
               step_in    = STEP_W'(1);
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            dp_ctrl.op = DP_DIV_STEP;
            step_in    = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            map_raddr = quot_idx;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            map_raddr = quot_idx;
            if (slot_free) begin
               finish   = 1'b1;
               state_in = S_IDLE;
               if (quot_in_range && !map_rd_ff) begin
                  result.ok = 1'b1;
                  map_we    = 1'b1;
                  map_waddr = quot_idx;
                  map_wdata = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in = finish ? result : rsp_ff;
      priority if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (map_we) begin
         free_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= free_mem[map_raddr];
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `BFA_ASSERT(a_rsp_src, clock, reset, $rose(rsp_valid_ff) |-> $past(finish), "stray result")
   `BFA_ASSERT(a_map_wr, clock, reset, map_we && state_ff != S_INIT |-> finish, "stray map write")
   `BFA_ASSERT(a_scan, clock, reset, idx_ff <= LAST_IDX, "index past end")
   `BFA_ASSERT_NR(a_reset, clock, reset |=> state_ff == S_INIT && !rsp_valid_ff, "bad reset")

endmodule

/* sv/bitmap_fixed_block_allocator.sv */
// top level of the bitmap fixed-size block allocator
// Fixed-size block allocator with one free bit per block. An allocate
// transfer (opcode 0) takes the lowest free block and returns base_address +
// index * block_size; a free transfer (opcode 1) turns free_address back into
// a block index by (free_address - base_address) / block_size and releases
// that block if it was in use. Every request transfer gives exactly one
// result transfer. The free map is a one-bit memory with a registered read;
// after reset a clearing pass marks every block free, one entry per cycle,
// so req_stall stays high until that pass is over. Requests are
// handled one at a time: req_stall is high from acceptance until the result
// is in the output register. An allocate scans the map upward from block 0,
// testing one map entry per cycle while the shared adder steps the running
// address by block_size; it returns the first free block, or fails when
// the map is full. A free runs the offset subtract in the acceptance cycle,
// a borrow check that also runs the first of 32 restoring division steps on
// the same adder, 31 more steps, one bit per cycle, one map read and one map
// update; an address below base_address or a block size of zero is rejected
// at the borrow check. A finished result waits in the sequencer while the
// output register still holds an earlier one under rsp_stall, and the output
// register lets a new request in while a result still waits on rsp_stall.
// Registers are written through csr_write/csr_index/csr_wdata and should
// only change while no request is in progress.

module bitmap_fixed_block_allocator
   import bfa_pkg::*;
#(
   parameter int NUM_BLOCKS = 64
)
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp,
   // register write port
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]      csr_wdata
);

   // configuration registers
   logic [ADDR_W-1:0] base_address_ff, base_address_in;
   logic [SIZE_W-1:0] block_size_ff, block_size_in;

   // sequencer to datapath control and status
   dp_ctrl_type dp_ctrl;
   dp_stat_type dp_stat;

   // register writes, block size keeps its low bits
   always_comb begin
      base_address_in = base_address_ff;
      block_size_in   = block_size_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_address_in = csr_wdata;
            CSR_BLOCK_SIZE:   block_size_in   = csr_wdata[SIZE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= BASE_ADDRESS_RESET;
         block_size_ff   <= BLOCK_SIZE_RESET;
      end else begin
         base_address_ff <= base_address_in;
         block_size_ff   <= block_size_in;
      end
   end

   // free map, scan, division steps and result register
   bfa_seq #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .block_size (block_size_ff),
      .dp_ctrl    (dp_ctrl),
      .dp_stat    (dp_stat),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   // shared adder for address stepping, offset and division
   // the offset subtract reads free_address in the acceptance cycle
   bfa_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (dp_ctrl),
      .base_address (base_address_ff),
      .block_size   (block_size_ff),
      .free_address (req.free_address),
      .stat         (dp_stat)
   );

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the bitmap fixed-size block allocator
module tb_top;
   import bfa_pkg::*;

   localparam int NUM_BLOCKS  = 64;
   // cycles with no transfer on either channel before the run is declared hung;
   // it has to cover a full-map allocate or a free, and the receiver stalls at
   // random on top of that
   localparam int STALL_LIMIT = 3000;
   // quiet cycles after the last result, longer than the slowest request
   localparam int TAIL_CYCLES = 2 * NUM_BLOCKS;
   // settle time before a register write once nothing is outstanding
   localparam int CSR_SETTLE  = 4;

   // predictor of the allocator plus the store of expected results
   class alloc_scoreboard_type;
      bit [NUM_BLOCKS-1:0] free_map;
      bit [ADDR_W-1:0]     base;
      bit [SIZE_W-1:0]     bsize;
      rsp_type             expected_q[$];
      int                  mismatches;
      int                  alloc_ok, alloc_full, free_ok, free_bad;

      function new();
         free_map   = '1;
         base       = BASE_ADDRESS_RESET;
         bsize      = BLOCK_SIZE_RESET;
         mismatches = 0;
         alloc_ok   = 0;
         alloc_full = 0;
         free_ok    = 0;
         free_bad   = 0;
      endfunction

      // register writes mask to the register width
      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [ADDR_W-1:0] data);
         if (idx == CSR_BASE_ADDRESS) begin
            base = data;
         end else if (idx == CSR_BLOCK_SIZE) begin
            bsize = data[SIZE_W-1:0];
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // work out the result of one accepted request and update the free map
      function void note_request(req_type item);
         rsp_type         res;
         bit              found;
         bit [ADDR_W-1:0] offset;
         bit [ADDR_W-1:0] slot;
         res   = '0;
         found = 1'b0;
         if (item.opcode == OP_ALLOC) begin
            // lowest free block wins, address wraps modulo 2^32
            for (int k = 0; k < NUM_BLOCKS; k++) begin
               if (!found && free_map[k]) begin
                  found             = 1'b1;
                  free_map[k]       = 1'b0;
                  res.ok            = 1'b1;
                  res.block_address = base + 32'(k) * 32'(bsize);
               end
            end
            if (found) alloc_ok++;
            else alloc_full++;
         end else begin
            // below base or zero size: rejected outright
            if (item.free_address >= base && bsize != 0) begin
               offset = item.free_address - base;
               slot   = offset / 32'(bsize);
               // past the last block, or a double free, is rejected
               if (slot < NUM_BLOCKS) begin
                  if (!free_map[slot]) begin
                     free_map[slot] = 1'b1;
                     res.ok         = 1'b1;
                  end
               end
            end
            if (res.ok) free_ok++;
            else free_bad++;
         end
         expected_q.push_back(res);
      endfunction

      function void flag(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%s: expected ok=%0b addr=%h, got ok=%0b addr=%h",
                     what, want.ok, want.block_address, got.ok, got.block_address);
      endfunction

      // compare a result transfer against the oldest expectation
      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            flag("result with nothing outstanding", '0, got);
         end else begin
            want = expected_q.pop_front();
            if (got.ok !== want.ok || got.block_address !== want.block_address)
               flag("result mismatch", want, got);
         end
      endfunction

      // some block currently in use, for well-formed frees
      function bit pick_used(output int idx);
         int used_q[$];
         idx = 0;
         for (int k = 0; k < NUM_BLOCKS; k++)
            if (!free_map[k]) used_q.push_back(k);
         if (used_q.size() == 0) return 1'b0;
         idx = used_q[$urandom_range(used_q.size() - 1)];
         return 1'b1;
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BASE_ADDRESS;
   logic [ADDR_W-1:0]      csr_wdata = '0;

   // handshake state sampled mid-cycle, when every signal is settled
   bit      req_take = 1'b0;
   bit      rsp_take = 1'b0;
   rsp_type rsp_seen;

   // idle rates in percent for the request and result side
   int send_idle = 11;
   int recv_idle = 70;
   int quiet_cycles = 0;
   int n_settings = 0;

   alloc_scoreboard_type sb = new();

   bitmap_fixed_block_allocator #(.NUM_BLOCKS(NUM_BLOCKS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // nothing is driven between edges, so values at the falling edge are the
   // ones the next rising edge acts on
   always @(negedge clock) begin
      req_take = !reset && req_valid === 1'b1 && req_stall === 1'b0;
      rsp_take = !reset && rsp_valid === 1'b1 && rsp_stall === 1'b0;
      rsp_seen = rsp;
   end

   // receiver: random stall, check every result transfer
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
      if (rsp_take) sb.check_result(rsp_seen);
   end

   // watchdog on stretches with no transfer at all
   always @(posedge clock) begin
      if (req_take || rsp_take) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // present one request, with random idle cycles ahead of it, until accepted;
   // returns at the edge of the transfer with valid still high
   task automatic send_req(input logic op, input logic [ADDR_W-1:0] addr);
      req_type item;
      item.opcode       = op;
      item.free_address = addr;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= item;
      @(posedge clock);
      while (!req_take) @(posedge clock);
      sb.note_request(item);
   endtask

   // stop sending until every expected result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // registers change only with the allocator idle
   task automatic reconfigure(input logic [ADDR_W-1:0] base_v,
                              input logic [ADDR_W-1:0] size_v);
      drain_results();
      repeat (CSR_SETTLE) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_BASE_ADDRESS;
      csr_wdata <= base_v;
      sb.write_reg(CSR_BASE_ADDRESS, base_v);
      @(posedge clock);
      csr_index <= CSR_BLOCK_SIZE;
      csr_wdata <= size_v;
      sb.write_reg(CSR_BLOCK_SIZE, size_v);
      @(posedge clock);
      csr_write <= 1'b0;
      n_settings++;
   endtask

   // random traffic: bursts lean toward allocate or toward free, so the map
   // fills up and empties again; most frees target blocks in use
   task automatic run_phase(input int n_items);
      int                alloc_pct;
      int                sel;
      int                idx;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] off;
      alloc_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (i % 16 == 0) begin
            case ($urandom_range(2))
               0: alloc_pct = 90;
               1: alloc_pct = 50;
               default: alloc_pct = 15;
            endcase
         end
         if ($urandom_range(99) < alloc_pct) begin
            send_req(OP_ALLOC, $urandom);
         end else begin
            off = (sb.bsize == 0) ? '0 : $urandom_range(sb.bsize - 1);
            sel = $urandom_range(99);
            if (sel < 60 && sb.pick_used(idx)) begin
               addr = sb.base + 32'(idx) * 32'(sb.bsize) + off;
            end else if (sel < 75) begin
               // any index, a few past the last block
               idx  = $urandom_range(NUM_BLOCKS + 3);
               addr = sb.base + 32'(idx) * 32'(sb.bsize) + off;
            end else if (sel < 85 && sb.base != 0) begin
               addr = $urandom_range(sb.base - 1);
            end else begin
               addr = $urandom;
            end
            send_req(OP_FREE, addr);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: base 0, 16-byte blocks; first allocation lands at 0
      send_req(OP_ALLOC, $urandom);
      send_req(OP_ALLOC, $urandom);
      send_req(OP_ALLOC, $urandom);
      send_req(OP_FREE, 32'h0000_0010);
      // double free
      send_req(OP_FREE, 32'h0000_0010);
      // unaligned address inside block 2
      send_req(OP_FREE, 32'h0000_0025);
      // index past the last block
      send_req(OP_FREE, 32'h0000_0400);
      send_req(OP_FREE, 32'hFFFF_FFFF);
      send_req(OP_FREE, 32'h0000_000F);
      send_req(OP_ALLOC, $urandom);

      // one-byte blocks, nonzero base: addresses below base are rejected
      reconfigure(32'h0000_1000, 32'd1);
      send_req(OP_FREE, 32'h0000_0FFF);
      send_req(OP_FREE, 32'h0000_0000);
      send_req(OP_ALLOC, $urandom);
      send_req(OP_FREE, 32'h0000_1001);
      send_req(OP_FREE, 32'h0000_103F);

      // zero block size: allocate returns base, every free fails
      reconfigure(32'h0000_1000, 32'd0);
      send_req(OP_ALLOC, $urandom);
      send_req(OP_FREE, 32'h0000_1000);

      // top base and largest size, upper write bits masked: blocks past the
      // first wrap below base and can not be freed
      reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(OP_ALLOC, $urandom);
      send_req(OP_FREE, 32'hFFFF_FFFF);
      send_req(OP_ALLOC, $urandom);
      send_req(OP_FREE, 32'h0000_FFFE);

      // random part, sender idles lightly, receiver heavily
      reconfigure(32'h0000_0000, 32'd16);
      run_phase(60);
      reconfigure($urandom, $urandom_range(65535, 1));
      run_phase(60);
      reconfigure(32'hFFFF_F000, 32'h0000_0100);
      run_phase(60);

      // sender idles heavily, receiver lightly
      send_idle = 70;
      recv_idle = 11;
      reconfigure($urandom, 32'hFFFF_0001);
      run_phase(60);
      reconfigure(32'h0000_0000, 32'd65535);
      run_phase(60);

      // back to back on both sides
      send_idle = 0;
      recv_idle = 0;
      reconfigure(32'h8000_0000, 32'd3);
      run_phase(60);
      reconfigure($urandom, 32'd0);
      run_phase(25);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d allocations (%0d with the map full) and %0d frees (%0d rejected)",
               sb.alloc_ok + sb.alloc_full, sb.alloc_full,
               sb.free_ok + sb.free_bad, sb.free_bad);
      $display("over %0d register settings, %0d mismatches", n_settings, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
